### src/slope_sign_peak_finder_macros.svh
// Assertion macros used by the peak finder back end.
`ifndef SLOPE_SIGN_PEAK_FINDER_MACROS_SVH
`define SLOPE_SIGN_PEAK_FINDER_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define SSPF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define SSPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the following cycle.
`define SSPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sspf_pkg.sv
// Types, constants and helpers shared by the peak finder modules.
package sspf_pkg;

	localparam int PEAK_DEPTH    = 16;
	localparam int IDX_BITS      = 16;
	localparam int PEAK_CNT_BITS = $clog2(PEAK_DEPTH + 1);
	localparam int PEAK_PTR_BITS = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
	localparam logic [PEAK_CNT_BITS-1:0] PEAK_FULL = PEAK_CNT_BITS'(PEAK_DEPTH);

	localparam int MID_DEPTH     = 4;
	localparam int MID_PTR_BITS  = $clog2(MID_DEPTH);
	localparam int MID_CNT_BITS  = $clog2(MID_DEPTH + 1);

	localparam int OUT_DEPTH     = 2;
	localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		REG_MIN_HEIGHT   = 2'd0,
		REG_MIN_DISTANCE = 2'd1,
		REG_MAX_PEAKS    = 2'd2
	} reg_idx_t;

	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [4:0] MAX_PEAKS_RESET = 5'd16;

	typedef struct packed {
		logic [15:0] height_floor;
		logic [15:0] spacing;
		logic [4:0]  peak_cap;
	} cfg_t;

	// Classified sample handed from the front to the back.
	typedef struct packed {
		logic                       cand;
		logic signed [15:0]         pos;
		logic signed [15:0]         height;
		logic [IDX_BITS-1:0]        idx;
		logic                       last;
	} mid_item_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] position;
		logic signed [15:0] height;
		logic [15:0]        index;
		logic [4:0]         total;
		logic               is_last;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Low 16 bits of a sample index, zero-extended when the index is narrower.
	function automatic logic [15:0] index16(input logic [IDX_BITS-1:0] v);
		logic [IDX_BITS+15:0] t;
		t = {16'b0, v};
		return t[15:0];
	endfunction

endpackage

### src/sspf_front.sv
// Front end: keeps the sample window and slope sign, classifies peak candidates.
module sspf_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sspf_pkg::cfg_t            cfg,
	input  logic                      push,
	input  logic signed [15:0]        x_value,
	input  logic signed [15:0]        y_value,
	input  logic                      last_sample,
	input  sspf_pkg::queue_stat_t     mid_stat,
	output logic                      mid_push,
	output sspf_pkg::mid_item_t       mid_item
);

	logic signed [15:0]              wx0_q, wx1_q, wy0_q, wy1_q;
	logic                            prev_rise_q;
	logic [sspf_pkg::IDX_BITS-1:0]   count_q;
	logic [1:0]                      fill_q;

	logic signed [16:0] dy, dx, yext;
	logic [16:0]        ay;
	logic               rising;
	logic               accept;

	assign accept   = push && !mid_stat.full;
	assign mid_push = accept;

	always_comb begin
		dy     = {y_value[15], y_value} - {wy0_q[15], wy0_q};
		dx     = {x_value[15], x_value} - {wx0_q[15], wx0_q};
		rising = (dy != 17'sd0) && (dy[16] == dx[16]);
		yext   = {wy1_q[15], wy1_q};
		ay     = yext[16] ? 17'(-yext) : 17'(yext);

		mid_item.cand   = (fill_q == 2'd3) && prev_rise_q && !rising &&
		                  (ay > {1'b0, cfg.height_floor});
		mid_item.pos    = wx1_q;
		mid_item.height = wy1_q;
		mid_item.idx    = count_q - sspf_pkg::IDX_BITS'(1);
		mid_item.last   = last_sample;
	end

	// Window payload needs no reset: it is read only once the fill count covers it.
	always_ff @(posedge clk) begin
		if (accept) begin
			wx0_q <= wx1_q;
			wy0_q <= wy1_q;
			wx1_q <= x_value;
			wy1_q <= y_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rise_q <= 1'b0;
			count_q     <= '0;
			fill_q      <= 2'd0;
		end else if (accept) begin
			if (last_sample) begin
				prev_rise_q <= 1'b0;
				count_q     <= '0;
				fill_q      <= 2'd0;
			end else begin
				count_q <= count_q + sspf_pkg::IDX_BITS'(1);
				if (fill_q != 2'd3)
					fill_q <= fill_q + 2'd1;
				if (fill_q >= 2'd2)
					prev_rise_q <= rising;
			end
		end
	end

endmodule

### src/sspf_queue.sv
// Short queue of classified samples between the front and the back.
module sspf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  sspf_pkg::mid_item_t   wdata,
	input  logic                  rd,
	output sspf_pkg::mid_item_t   rdata,
	output sspf_pkg::queue_stat_t stat
);

	sspf_pkg::mid_item_t                 mem_q [sspf_pkg::MID_DEPTH];
	logic [sspf_pkg::MID_PTR_BITS-1:0]   wp_q, rp_q;
	logic [sspf_pkg::MID_CNT_BITS-1:0]   cnt_q;
	logic                                do_wr, do_rd;

	assign stat.full  = (cnt_q == sspf_pkg::MID_CNT_BITS'(sspf_pkg::MID_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rdata      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + sspf_pkg::MID_PTR_BITS'(1);
			if (do_rd)
				rp_q <= rp_q + sspf_pkg::MID_PTR_BITS'(1);
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + sspf_pkg::MID_CNT_BITS'(1);
				2'b01:   cnt_q <= cnt_q - sspf_pkg::MID_CNT_BITS'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/sspf_back.sv
// Back end: distance check against stored peaks, peak limit, result queue.
`include "slope_sign_peak_finder_macros.svh"

module sspf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sspf_pkg::cfg_t        cfg,
	input  sspf_pkg::mid_item_t   head,
	input  logic                  head_valid,
	output logic                  head_pop,
	input  logic                  pop,
	output logic                  empty,
	output sspf_pkg::result_t     res
);

	logic signed [15:0]                   store_q [sspf_pkg::PEAK_DEPTH];
	logic [sspf_pkg::PEAK_CNT_BITS-1:0]   found_q, found_d;
	logic                                 sum_pend_q, sum_d;

	sspf_pkg::result_t                    oq_q [sspf_pkg::OUT_DEPTH];
	logic [sspf_pkg::OUT_PTR_BITS-1:0]    owp_q, orp_q;
	logic [sspf_pkg::OUT_CNT_BITS-1:0]    ocnt_q;

	logic [sspf_pkg::PEAK_CNT_BITS-1:0]   limit;
	logic                                 close;
	logic                                 peak_ok;
	logic                                 owr, opop, ospace;
	logic                                 st_we;
	logic                                 peak_on_last;
	sspf_pkg::result_t                    ores;
	logic signed [16:0]                   sep;
	logic [16:0]                          asep;

	always_comb begin
		if (32'(cfg.peak_cap) >= sspf_pkg::PEAK_DEPTH)
			limit = sspf_pkg::PEAK_FULL;
		else
			limit = sspf_pkg::PEAK_CNT_BITS'(cfg.peak_cap);
	end

	// One comparator per store entry; only entries below the fill count take part.
	always_comb begin
		close = 1'b0;
		sep   = '0;
		asep  = '0;
		for (int k = 0; k < sspf_pkg::PEAK_DEPTH; k++) begin
			sep  = {head.pos[15], head.pos} - {store_q[k][15], store_q[k]};
			asep = sep[16] ? 17'(-sep) : 17'(sep);
			if ((sspf_pkg::PEAK_CNT_BITS'(k) < found_q) &&
			    (asep < {1'b0, cfg.spacing}))
				close = 1'b1;
		end
	end

	assign peak_ok = head.cand && (found_q < limit) && !close;
	assign ospace  = (ocnt_q != sspf_pkg::OUT_CNT_BITS'(sspf_pkg::OUT_DEPTH));

	always_comb begin
		owr      = 1'b0;
		head_pop = 1'b0;
		st_we    = 1'b0;
		found_d  = found_q;
		sum_d    = sum_pend_q;
		ores     = '0;
		if (head_valid && ospace) begin
			if (sum_pend_q) begin
				// peak already out; finish with the summary
				ores.kind  = sspf_pkg::KIND_SUMMARY;
				ores.total = 5'(found_q);
				ores.is_last = 1'b1;
				owr      = 1'b1;
				head_pop = 1'b1;
				found_d  = '0;
				sum_d    = 1'b0;
			end else if (peak_ok) begin
				ores.kind     = sspf_pkg::KIND_PEAK;
				ores.position = head.pos;
				ores.height   = head.height;
				ores.index    = sspf_pkg::index16(head.idx);
				ores.is_last  = !head.last;
				owr     = 1'b1;
				st_we   = 1'b1;
				found_d = found_q + sspf_pkg::PEAK_CNT_BITS'(1);
				if (head.last)
					sum_d = 1'b1;
				else
					head_pop = 1'b1;
			end else begin
				head_pop = 1'b1;
				if (head.last) begin
					ores.kind    = sspf_pkg::KIND_SUMMARY;
					ores.total   = 5'(found_q);
					ores.is_last = 1'b1;
					owr     = 1'b1;
					found_d = '0;
				end
			end
		end
	end

	assign peak_on_last = owr && (ores.kind == sspf_pkg::KIND_PEAK) && head.last;

	always_ff @(posedge clk) begin
		if (st_we)
			store_q[found_q[sspf_pkg::PEAK_PTR_BITS-1:0]] <= head.pos;
		if (owr)
			oq_q[owp_q] <= ores;
	end

	assign empty = (ocnt_q == '0);
	assign opop  = pop && !empty;
	assign res   = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= '0;
			sum_pend_q <= 1'b0;
			owp_q      <= '0;
			orp_q      <= '0;
			ocnt_q     <= '0;
		end else begin
			found_q    <= found_d;
			sum_pend_q <= sum_d;
			if (owr)
				owp_q <= owp_q + sspf_pkg::OUT_PTR_BITS'(1);
			if (opop)
				orp_q <= orp_q + sspf_pkg::OUT_PTR_BITS'(1);
			case ({owr, opop})
				2'b10:   ocnt_q <= ocnt_q + sspf_pkg::OUT_CNT_BITS'(1);
				2'b01:   ocnt_q <= ocnt_q - sspf_pkg::OUT_CNT_BITS'(1);
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	`SSPF_ASSERT_IMP(a_pend_has_head, sum_pend_q, head_valid, "summary pending, queue empty")
	`SSPF_ASSERT_NXT(a_peak_then_sum, peak_on_last, sum_pend_q, "no summary after last peak")
	`SSPF_ASSERT_ALWAYS(a_found_bound, found_q <= sspf_pkg::PEAK_FULL, "peak count over depth")
	`SSPF_ASSERT_IMP(a_pop_valid, head_pop, head_valid, "back popped an empty queue")

endmodule

### src/slope_sign_peak_finder.sv
// Top level of the slope-sign peak finder: configuration registers and the front/back split.
//
// Samples enter through push/full and are classified by the front end in the cycle they are
// accepted; a new sample can be taken every cycle while the four-entry classified-sample
// queue has room. The back end retires one queued sample per cycle while its two-entry
// result queue has room; a peak on the last sample of a sequence holds that sample until
// both the peak report and then the summary are written, since it writes one result per
// cycle. A result passes through the classified-sample queue and then the result queue
// before it appears on the outputs; the summary behind a peak on the last sample follows the peak report.
// Configuration writes are taken at once and must only happen while the block is idle.
module slope_sign_peak_finder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] x_value,
	input  logic signed [15:0] y_value,
	input  logic               last_sample,
	output logic               empty,
	input  logic               pop,
	output logic               kind,
	output logic signed [15:0] peak_position,
	output logic signed [15:0] peak_height,
	output logic [15:0]        peak_index,
	output logic [4:0]         peak_total,
	output logic               is_last
);

	sspf_pkg::cfg_t        cfg_q;
	sspf_pkg::queue_stat_t mid_stat;
	sspf_pkg::mid_item_t   mid_in, mid_head;
	sspf_pkg::result_t     res;
	logic                  mid_push, mid_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height_floor <= '0;
			cfg_q.spacing      <= '0;
			cfg_q.peak_cap     <= sspf_pkg::MAX_PEAKS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sspf_pkg::REG_MIN_HEIGHT:   cfg_q.height_floor <= cfg_data;
				sspf_pkg::REG_MIN_DISTANCE: cfg_q.spacing      <= cfg_data;
				sspf_pkg::REG_MAX_PEAKS:    cfg_q.peak_cap     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign full = mid_stat.full;

	sspf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.x_value     (x_value),
		.y_value     (y_value),
		.last_sample (last_sample),
		.mid_stat    (mid_stat),
		.mid_push    (mid_push),
		.mid_item    (mid_in)
	);

	sspf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_push),
		.wdata  (mid_in),
		.rd     (mid_pop),
		.rdata  (mid_head),
		.stat   (mid_stat)
	);

	sspf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (mid_head),
		.head_valid (!mid_stat.empty),
		.head_pop   (mid_pop),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign kind          = res.kind;
	assign peak_position = res.position;
	assign peak_height   = res.height;
	assign peak_index    = res.index;
	assign peak_total    = res.total;
	assign is_last       = res.is_last;

endmodule

### bench/tb_slope_sign_peak_finder.sv
// Self-checking testbench for the slope-sign peak finder with its own peak predictor.
`timescale 1ns / 1ps

module tb_slope_sign_peak_finder;

	localparam int HALF_PERIOD   = 6;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 8;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_write   = 1'b0;
	logic [1:0]         cfg_index   = '0;
	logic [15:0]        cfg_data    = '0;
	logic               push        = 1'b0;
	logic               full;
	logic signed [15:0] x_value     = '0;
	logic signed [15:0] y_value     = '0;
	logic               last_sample = 1'b0;
	logic               empty;
	logic               pop         = 1'b0;
	logic               kind;
	logic signed [15:0] peak_position;
	logic signed [15:0] peak_height;
	logic [15:0]        peak_index;
	logic [4:0]         peak_total;
	logic               is_last;

	// Predictor state: limits and the per-sequence peak search.
	logic [15:0]        lim_height   = '0;
	logic [15:0]        lim_distance = '0;
	logic [4:0]         lim_peaks    = sspf_pkg::MAX_PEAKS_RESET;
	logic signed [15:0] win_x [2]    = '{default: '0};
	logic signed [15:0] win_y [2]    = '{default: '0};
	logic               was_rising   = 1'b0;
	logic [15:0]        sample_count = '0;
	logic signed [15:0] peak_xs [sspf_pkg::PEAK_DEPTH];
	int                 peaks_found  = 0;
	int                 window_fill  = 0;
	sspf_pkg::result_t  pending_results [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int pop_hold       = 0;
	bit steady         = 1'b0;

	slope_sign_peak_finder u_top (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_slope_sign_peak_finder: done, errors");
			$finish;
		end
	end

	function automatic int idle_span();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	task automatic clear_sequence_model();
		win_x        = '{default: '0};
		win_y        = '{default: '0};
		was_rising   = 1'b0;
		sample_count = '0;
		peaks_found  = 0;
		window_fill  = 0;
	endtask

	// Work out the results that one accepted sample causes.
	task automatic detect_peak(input logic signed [15:0] x, y, input logic last);
		int                dy, dx, limit, ay, sep;
		bit                rising, near;
		sspf_pkg::result_t r;
		limit = (lim_peaks < sspf_pkg::PEAK_DEPTH) ? int'(lim_peaks) : sspf_pkg::PEAK_DEPTH;
		if (window_fill >= 2) begin
			dy = int'(y) - int'(win_y[0]);
			dx = int'(x) - int'(win_x[0]);
			rising = (dy != 0) && ((dy > 0) == (dx >= 0));
			if (window_fill >= 3 && was_rising && !rising && peaks_found < limit) begin
				ay = (win_y[1] < 0) ? -int'(win_y[1]) : int'(win_y[1]);
				if (ay > int'(lim_height)) begin
					near = 1'b0;
					for (int k = 0; k < peaks_found; k++) begin
						sep = int'(win_x[1]) - int'(peak_xs[k]);
						if (sep < 0)
							sep = -sep;
						if (sep < int'(lim_distance))
							near = 1'b1;
					end
					if (!near) begin
						peak_xs[peaks_found] = win_x[1];
						peaks_found++;
						r = '0;
						r.kind     = sspf_pkg::KIND_PEAK;
						r.position = win_x[1];
						r.height   = win_y[1];
						r.index    = sample_count - 16'd1;
						r.is_last  = !last;
						pending_results.push_back(r);
					end
				end
			end
			was_rising = rising;
		end
		win_x[0] = win_x[1];
		win_y[0] = win_y[1];
		win_x[1] = x;
		win_y[1] = y;
		sample_count++;
		if (window_fill < 3)
			window_fill++;
		if (last) begin
			r = '0;
			r.kind    = sspf_pkg::KIND_SUMMARY;
			r.total   = 5'(peaks_found);
			r.is_last = 1'b1;
			pending_results.push_back(r);
			clear_sequence_model();
		end
	endtask

	always @(posedge clk) begin
		sspf_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 16'(kind), 16'(want.kind));
				check_field("peak_position", peak_position, want.position);
				check_field("peak_height", peak_height, want.height);
				check_field("peak_index", peak_index, want.index);
				check_field("peak_total", 16'(peak_total), 16'(want.total));
				check_field("is_last", 16'(is_last), 16'(want.is_last));
			end
		end
	end

	// Stall the result side at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 99) < 25)
				pop_hold = idle_span();
		end
	end

	// Enter and leave at a falling edge.
	task automatic send_sample(input logic signed [15:0] x, y, input logic last);
		int gap;
		gap = idle_span();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push        <= 1'b1;
		x_value     <= x;
		y_value     <= y;
		last_sample <= last;
		do @(posedge clk); while (full);
		detect_peak(x, y, last);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all three registers back to back; the peak limit keeps only its low bits.
	task automatic set_limits(input logic [15:0] height, distance, most);
		cfg_write <= 1'b1;
		cfg_index <= sspf_pkg::REG_MIN_HEIGHT;
		cfg_data  <= height;
		@(negedge clk);
		cfg_index <= sspf_pkg::REG_MIN_DISTANCE;
		cfg_data  <= distance;
		@(negedge clk);
		cfg_index <= sspf_pkg::REG_MAX_PEAKS;
		cfg_data  <= most;
		@(negedge clk);
		cfg_write    <= 1'b0;
		lim_height   = height;
		lim_distance = distance;
		lim_peaks    = most[4:0];
	endtask

	// Hills, ramps and zigzags with random content.
	task automatic send_shaped(inout int sent);
		int len, xi, yi, dir, amp, trend, period, roll;
		bit zigzag;
		roll   = $urandom_range(0, 99);
		len    = (roll < 8) ? $urandom_range(1, 3) :
		         (roll < 92) ? $urandom_range(4, 40) : $urandom_range(60, 120);
		xi     = int'($urandom_range(0, 65535)) - 32768;
		yi     = int'($urandom_range(0, 65535)) - 32768;
		dir    = ($urandom_range(0, 3) == 0) ? -1 : 1;
		amp    = $urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(100, 4000);
		zigzag = ($urandom_range(0, 4) == 0);
		period = $urandom_range(1, 5);
		trend  = 1;
		for (int i = 0; i < len; i++) begin
			if (zigzag)
				trend = ((i / period) % 2 == 0) ? 1 : -1;
			else if ($urandom_range(0, 5) == 0)
				trend = -trend;
			yi += trend * int'($urandom_range(0, amp));
			if (yi > 32767) begin
				yi = 32767;
				trend = -1;
			end
			if (yi < -32768) begin
				yi = -32768;
				trend = 1;
			end
			if ($urandom_range(0, 40) == 0)
				yi = int'($urandom_range(0, 65535)) - 32768;
			send_sample(16'(xi), 16'(yi), i == len - 1);
			sent++;
			xi += ($urandom_range(0, 9) == 0) ? 0 : dir * int'($urandom_range(1, 8));
		end
	endtask

	// Raw noise; some runs leave the sequence open so it merges into the next one.
	task automatic send_noise(inout int sent);
		int len;
		bit close_it;
		len      = $urandom_range(1, 20);
		close_it = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < len; i++) begin
			send_sample(16'($urandom), 16'($urandom), close_it && (i == len - 1));
			sent++;
		end
	endtask

	task automatic run_random(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < 85)
				send_shaped(sent);
			else
				send_noise(sent);
		end
		steady = 1'b0;
		wait_idle();
	endtask

	task automatic test_peak_on_last();
		send_sample(16'sd0, 16'sd0, 1'b0);
		send_sample(16'sd1, 16'sd10, 1'b0);
		send_sample(16'sd2, 16'sd20, 1'b0);
		send_sample(16'sd3, 16'sd5, 1'b1);
		wait_idle();
	endtask

	task automatic test_short_sequences();
		send_sample(16'sd5, 16'sd7, 1'b1);
		send_sample(16'sd0, 16'sd0, 1'b0);
		send_sample(16'sd1, 16'sd9, 1'b0);
		send_sample(16'sd2, 16'sd0, 1'b1);
		wait_idle();
	endtask

	task automatic test_field_extremes();
		send_sample(-16'sd32768, -16'sd32768, 1'b0);
		send_sample(16'sd32767, 16'sd32767, 1'b0);
		send_sample(16'sd0, -16'sd32768, 1'b0);
		send_sample(16'sd0, 16'sd32767, 1'b0);
		send_sample(-16'sd1, -16'sd32768, 1'b0);
		send_sample(16'sd32767, 16'sd0, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(16'sd0, -16'sd1, 1'b1);
		wait_idle();
	endtask

	// Two candidates, room for one.
	task automatic test_peak_limit();
		int shape [9] = '{0, 1, 2, 1, 0, 1, 2, 1, 0};
		set_limits(16'd0, 16'd0, 16'd1);
		for (int i = 0; i < 9; i++)
			send_sample(16'(i), 16'(shape[i]), i == 8);
		wait_idle();
	endtask

	task automatic test_random_settings();
		set_limits(16'd0, 16'd0, 16'd16);
		run_random(250);
		set_limits(16'd32768, 16'hFFFF, 16'd0);
		run_random(150);
		set_limits(16'd0, 16'd0, 16'hFFFF);
		run_random(250);
		set_limits(16'hFFFF, 16'd0, 16'd16);
		run_random(100);
		repeat (4) begin
			set_limits(16'($urandom_range(0, 20000)), 16'($urandom_range(0, 300)),
			           16'($urandom_range(0, 16)) | (16'($urandom) & 16'hFFE0));
			run_random(200);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_peak_on_last();
		test_short_sequences();
		test_field_extremes();
		test_peak_limit();
		test_random_settings();
		if (mismatch_count == 0)
			$display("tb_slope_sign_peak_finder: done, clean");
		else
			$display("tb_slope_sign_peak_finder: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/sspf_pkg.sv
src/sspf_front.sv
src/sspf_queue.sv
src/sspf_back.sv
src/slope_sign_peak_finder.sv
bench/tb_slope_sign_peak_finder.sv
